FILE: rtl/sped_pkg.sv
`timescale 1ns / 1ps
package sped_pkg;

  // defaults of the top-level parameters
  localparam int SAMPLE_BITS_DEF     = 24;
  localparam int COEFF_FRAC_BITS_DEF = 16;

  // number of dry channels, one magnitude lane each
  localparam int LANES = 2;

  // wet gain, unsigned Q1.15
  localparam int             GAIN_BITS = 16;
  localparam logic [15:0]    GAIN_ONE  = 16'd32768;

  // register reset values, given at Q.16 coefficient and 23-bit level scale
  localparam int RELEASE_RST_Q16   = 655;
  localparam int THRESHOLD_RST_Q23 = 83886;

  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ATTACK,
    REG_RELEASE,
    REG_THRESHOLD,
    REG_DUCK_GAIN,
    REG_DUCK_ENABLE,
    REG_ACTIVE_CH
  } cfg_reg_t;

endpackage

FILE: rtl/sped_lane.sv
`timescale 1ns / 1ps
module sped_lane #(
  parameter int SAMPLE_BITS = sped_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic        [SAMPLE_BITS-2:0] mag
);
  import sped_pkg::*;

  localparam int LW = SAMPLE_BITS - 1;

  logic [SAMPLE_BITS-1:0] negated;
  logic [LW-1:0]          mag_next;

  always_comb begin
    negated = ~sample + SAMPLE_BITS'(1);
    if (!sample[SAMPLE_BITS-1]) begin
      mag_next = sample[LW-1:0];
    end else if (negated[SAMPLE_BITS-1]) begin
      // most negative code saturates to the top level
      mag_next = {LW{1'b1}};
    end else begin
      mag_next = negated[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mag <= mag_next;
    end
  end

endmodule

FILE: rtl/sped_env.sv
`timescale 1ns / 1ps
module sped_env #(
  parameter int SAMPLE_BITS     = sped_pkg::SAMPLE_BITS_DEF,
  parameter int COEFF_FRAC_BITS = sped_pkg::COEFF_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                go,
  input  logic                                last,
  input  logic [SAMPLE_BITS-2:0]              mag_l,
  input  logic [SAMPLE_BITS-2:0]              mag_r,
  input  logic                                single_ch,
  input  logic [COEFF_FRAC_BITS:0]            atk_coeff,
  input  logic [COEFF_FRAC_BITS:0]            rel_coeff,
  input  logic [SAMPLE_BITS-2:0]              thr,
  input  logic [sped_pkg::GAIN_BITS-1:0]      duck_gain,
  input  logic                                duck_enable,
  output logic [sped_pkg::GAIN_BITS-1:0]      res_gain,
  output logic [SAMPLE_BITS-2:0]              res_peak,
  output logic                                res_duck
);
  import sped_pkg::*;

  localparam int LW = SAMPLE_BITS - 1;
  localparam int CW = COEFF_FRAC_BITS + 1;
  localparam int PW = LW + CW;
  localparam logic [CW-1:0] CoeffOne = CW'(1) << COEFF_FRAC_BITS;
  localparam logic [PW-1:0] RoundHalf = PW'(1) << (COEFF_FRAC_BITS - 1);

  logic [LW-1:0] env_lvl;
  logic [LW-1:0] blk_max;

  logic [LW-1:0] peak;
  logic          up;
  logic [LW-1:0] diff;
  logic [CW-1:0] coeff;
  logic [CW-1:0] coeff_sat;
  logic [PW-1:0] prod;
  logic [PW-1:0] rounded;
  logic [LW-1:0] step;
  logic [LW-1:0] env_next;
  logic [LW-1:0] max_next;

  always_comb begin
    // merge the lanes
    peak = mag_l;
    if (!single_ch && (mag_r > mag_l)) begin
      peak = mag_r;
    end

    up        = peak > env_lvl;
    diff      = up ? (peak - env_lvl) : (env_lvl - peak);
    coeff     = up ? atk_coeff : rel_coeff;
    coeff_sat = (coeff > CoeffOne) ? CoeffOne : coeff;
    prod      = {{CW{1'b0}}, diff} * {{LW{1'b0}}, coeff_sat};
    rounded   = prod + RoundHalf;
    // step never exceeds diff, so it fits the level width
    step      = rounded[COEFF_FRAC_BITS +: LW];
    env_next  = up ? (env_lvl + step) : (env_lvl - step);
    max_next  = (env_next > blk_max) ? env_next : blk_max;

    res_peak = max_next;
    res_duck = duck_enable && (max_next > thr);
    res_gain = GAIN_ONE;
    if (res_duck) begin
      res_gain = (duck_gain > GAIN_ONE) ? GAIN_ONE : duck_gain;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      env_lvl <= '0;
      blk_max <= '0;
    end else if (go) begin
      env_lvl <= env_next;
      // next block starts its maximum from the current envelope
      blk_max <= last ? env_next : max_next;
    end
  end

endmodule

FILE: rtl/sidechain_peak_envelope_ducker_top.sv
`timescale 1ns / 1ps
// channel  dir  handshake             payload
// s_*      in   s_tvalid / s_tready   tdata: dry_left, dry_right; tlast: block_last
// m_*      out  m_tvalid / m_tready   tdata: wet_gain, block_peak_envelope;
//                                     tuser: ducking_active
// cfg_*    in   cfg_we                cfg_index, cfg_data
//
// one frame per cycle unless a block-end frame is held by a stalled result; a
// frame is registered in the magnitude lanes, then updates the envelope, and a
// block-end result is loaded into the output register as its frame leaves the lanes
// the envelope recursion (one multiply-add on its own value) sets the rate
// rst is synchronous; it restores the registers and clears envelope and block max
// while a result waits, non-final frames keep flowing past it, and the next
// block-end frame is taken into the lanes and held there
module sidechain_peak_envelope_ducker_top #(
  parameter int SAMPLE_BITS     = sped_pkg::SAMPLE_BITS_DEF,
  parameter int COEFF_FRAC_BITS = sped_pkg::COEFF_FRAC_BITS_DEF,
  localparam int LW   = SAMPLE_BITS - 1,
  localparam int CW   = COEFF_FRAC_BITS + 1,
  localparam int InW  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OutW = ((sped_pkg::GAIN_BITS + LW + 7) / 8) * 8,
  localparam int MaxLC = (LW > CW) ? LW : CW,
  localparam int CfgW = (MaxLC > sped_pkg::GAIN_BITS) ? MaxLC : sped_pkg::GAIN_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [InW-1:0]                      s_tdata,   // dry_left, dry_right
  input  logic                                s_tlast,   // block_last
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [OutW-1:0]                     m_tdata,   // wet_gain, block_peak_envelope
  output logic                                m_tuser,   // ducking_active
  input  logic                                cfg_we,
  input  logic [sped_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CfgW-1:0]                     cfg_data
);
  import sped_pkg::*;

  localparam logic [CW-1:0] AtkRst = CW'(1) << COEFF_FRAC_BITS;
  localparam logic [CW-1:0] RelRst = (COEFF_FRAC_BITS >= 16) ?
      CW'(RELEASE_RST_Q16 << (COEFF_FRAC_BITS - 16)) :
      CW'(RELEASE_RST_Q16 >> (16 - COEFF_FRAC_BITS));
  localparam logic [LW-1:0] ThrRst = (LW >= 23) ?
      LW'(THRESHOLD_RST_Q23 << (LW - 23)) :
      LW'(THRESHOLD_RST_Q23 >> (23 - LW));

  // configuration registers
  logic [CW-1:0]        atk_coeff;
  logic [CW-1:0]        rel_coeff;
  logic [LW-1:0]        thr;
  logic [GAIN_BITS-1:0] duck_gain;
  logic                 duck_enable;
  logic [1:0]           active_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      atk_coeff   <= AtkRst;
      rel_coeff   <= RelRst;
      thr         <= ThrRst;
      duck_gain   <= GAIN_ONE;
      duck_enable <= 1'b0;
      active_ch   <= 2'd2;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ATTACK:      atk_coeff   <= cfg_data[CW-1:0];
        REG_RELEASE:     rel_coeff   <= cfg_data[CW-1:0];
        REG_THRESHOLD:   thr         <= cfg_data[LW-1:0];
        REG_DUCK_GAIN:   duck_gain   <= cfg_data[GAIN_BITS-1:0];
        REG_DUCK_ENABLE: duck_enable <= cfg_data[0];
        REG_ACTIVE_CH:   active_ch   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // lane stage
  logic                 lane_valid;
  logic                 lane_last;
  logic                 in_load;
  logic                 out_free;
  logic                 env_go;
  logic [LW-1:0]        mags [LANES];

  assign out_free = !m_tvalid || m_tready;
  assign env_go   = lane_valid && (!lane_last || out_free);
  assign s_tready = !lane_valid || env_go;
  assign in_load  = s_tvalid && s_tready;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    sped_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk   (clk),
      .load  (in_load),
      .sample(s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS]),
      .mag   (mags[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= 1'b0;
    end else if (in_load) begin
      lane_valid <= 1'b1;
    end else if (env_go) begin
      lane_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      lane_last <= s_tlast;
    end
  end

  // envelope stage
  logic [GAIN_BITS-1:0] res_gain;
  logic [LW-1:0]        res_peak;
  logic                 res_duck;

  sped_env #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
  ) u_env (
    .clk        (clk),
    .rst        (rst),
    .go         (env_go),
    .last       (lane_last),
    .mag_l      (mags[0]),
    .mag_r      (mags[1]),
    .single_ch  (!active_ch[1]),
    .atk_coeff  (atk_coeff),
    .rel_coeff  (rel_coeff),
    .thr        (thr),
    .duck_gain  (duck_gain),
    .duck_enable(duck_enable),
    .res_gain   (res_gain),
    .res_peak   (res_peak),
    .res_duck   (res_duck)
  );

  // output register
  logic [GAIN_BITS-1:0] out_gain;
  logic [LW-1:0]        out_peak;
  logic                 out_duck;
  logic                 res_load;

  assign res_load = env_go && lane_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_gain <= res_gain;
      out_peak <= res_peak;
      out_duck <= res_duck;
    end
  end

  assign m_tdata = OutW'({out_peak, out_gain});
  assign m_tuser = out_duck;

  // a fresh result only follows a block-end frame leaving the lanes
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !$past(m_tvalid)) |-> $past(lane_valid && lane_last))
    else $error("result without a block-end frame");

  // a frame held in the lanes is not dropped
  a_lane_hold: assert property (@(posedge clk) disable iff (rst)
    (lane_valid && !env_go) |=> lane_valid)
    else $error("lane frame lost");

  // gain is unity unless ducking, and never above unity
  a_gain_unity: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (out_gain == GAIN_ONE))
    else $error("non-unity gain without ducking");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_gain <= GAIN_ONE))
    else $error("gain above unity");

endmodule

FILE: tb/sidechain_peak_envelope_ducker_top_test.sv
`timescale 1ns / 1ps
module sidechain_peak_envelope_ducker_top_test;
  import sped_pkg::*;

  // indexes past the last register, writes there must be dropped
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'(REG_ACTIVE_CH) + 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'(REG_ACTIVE_CH) + 3'd2;

  localparam int          CF          = COEFF_FRAC_BITS_DEF;
  localparam logic [16:0] COEFF_UNITY = 17'd1 << CF;
  localparam logic [63:0] COEFF_HALF  = 64'd1 << (CF - 1);
  localparam logic [22:0] LEVEL_TOP   = 23'h7FFFFF;
  localparam logic [23:0] SMP_MIN     = 24'h800000;
  localparam logic [23:0] SMP_MAX     = 24'h7FFFFF;

  typedef struct packed {
    logic [23:0] left;
    logic [23:0] right;
    logic        last;
  } frame_t;

  typedef struct packed {
    logic [15:0] gain;
    logic [22:0] peak;
    logic        duck;
  } result_t;

  typedef struct {
    bit                          is_cfg;
    logic [CFG_INDEX_BITS-1:0]   idx;
    logic [22:0]                 val;
    frame_t                      f;
    bit                          typed;
    result_t                     want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // dry_left, dry_right
  logic        s_tlast = 1'b0; // block_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // wet_gain, block_peak_envelope
  logic        m_tuser;        // ducking_active
  logic        cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [22:0] cfg_data = '0;

  sidechain_peak_envelope_ducker_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // register copies, reset values
  logic [16:0] atk_c   = 17'd65536;
  logic [16:0] rel_c   = 17'(RELEASE_RST_Q16);
  logic [22:0] thr     = 23'(THRESHOLD_RST_Q23);
  logic [15:0] dgain   = GAIN_ONE;
  logic        duck_en = 1'b0;
  logic [1:0]  chans   = 2'd2;

  logic [22:0] env_lvl = '0;
  logic [22:0] blk_max = '0;

  result_t   awaited_blocks[$];
  stim_row_t rows[$];
  int        mismatches = 0;
  int        frames_sent = 0;
  int        blocks_checked = 0;
  int        settings_used = 1;
  bit        steady_src = 1'b0;
  bit        steady_sink = 1'b0;
  int        hold_cnt = 0;

  function automatic logic [22:0] sat_mag(input logic [23:0] s);
    logic [24:0] m;
    m = s[23] ? (25'd1 << 24) - {1'b0, s} : {1'b0, s};
    return (m > 25'(LEVEL_TOP)) ? LEVEL_TOP : m[22:0];
  endfunction

  function automatic logic [22:0] env_step(input logic [22:0] d, input logic [16:0] c);
    logic [63:0] p;
    if (c > COEFF_UNITY) c = COEFF_UNITY;
    p = (64'(d) * 64'(c) + COEFF_HALF) >> CF;
    return p[22:0];
  endfunction

  function automatic void follow_envelope(input frame_t f, output bit emits,
                                          output result_t r);
    logic [22:0] pk;
    logic [22:0] rt;
    pk = sat_mag(f.left);
    if (chans >= 2'd2) begin
      rt = sat_mag(f.right);
      if (rt > pk) pk = rt;
    end
    if (pk > env_lvl) env_lvl = env_lvl + env_step(pk - env_lvl, atk_c);
    else env_lvl = env_lvl - env_step(env_lvl - pk, rel_c);
    if (env_lvl > blk_max) blk_max = env_lvl;
    emits = f.last;
    r.duck = duck_en && (blk_max > thr);
    r.gain = r.duck ? ((dgain > GAIN_ONE) ? GAIN_ONE : dgain) : GAIN_ONE;
    r.peak = blk_max;
    if (f.last) blk_max = env_lvl;
  endfunction

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [23:0] pick_sample();
    int r;
    logic [23:0] v;
    r = $urandom_range(0, 99);
    if (r < 8) return SMP_MIN;
    if (r < 14) return SMP_MAX;
    if (r < 18) return '0;
    if (r < 55) return 24'($urandom);
    // moderate levels, both signs, so the threshold gets crossed both ways
    v = 24'($urandom_range(0, (1 << $urandom_range(1, 22))));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx, input logic [22:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ATTACK:      atk_c = val[16:0];
      REG_RELEASE:     rel_c = val[16:0];
      REG_THRESHOLD:   thr = val;
      REG_DUCK_GAIN:   dgain = val[15:0];
      REG_DUCK_ENABLE: duck_en = val[0];
      REG_ACTIVE_CH:   chans = val[1:0];
      default: ;
    endcase
  endtask

  // stop sending and let every block result come out before touching registers
  task automatic drain();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (awaited_blocks.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic send_frame(input frame_t f, input bit typed, input result_t want);
    int gap;
    bit emits;
    result_t r;
    gap = (!steady_src && $urandom_range(0, 2) == 0) ? pick_pause() : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {f.right, f.left};
    s_tlast <= f.last;
    do @(posedge clk); while (!s_tready);
    follow_envelope(f, emits, r);
    if (emits) awaited_blocks.push_back(typed ? want : r);
    frames_sent++;
  endtask

  task automatic add_frame(input logic [23:0] l, input logic [23:0] r, input logic last);
    stim_row_t row;
    row = '{default: '0};
    row.f = '{left: l, right: r, last: last};
    rows.push_back(row);
  endtask

  task automatic add_checked(input logic [23:0] l, input logic [23:0] r,
                             input logic [15:0] g, input logic [22:0] pk, input logic dk);
    stim_row_t row;
    row = '{default: '0};
    row.f = '{left: l, right: r, last: 1'b1};
    row.typed = 1'b1;
    row.want = '{gain: g, peak: pk, duck: dk};
    rows.push_back(row);
  endtask

  task automatic add_cfg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [22:0] val);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = val;
    rows.push_back(row);
  endtask

  // block result checker and sink stalls
  always @(posedge clk) begin
    result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_blocks.size() == 0) begin
        $error("block result with nothing expected: tdata %h tuser %b", m_tdata, m_tuser);
        mismatches++;
      end else begin
        e = awaited_blocks.pop_front();
        blocks_checked++;
        if (m_tdata[15:0] !== e.gain) begin
          $error("wet_gain: expected %0d, got %0d", e.gain, m_tdata[15:0]);
          mismatches++;
        end
        if (m_tdata[38:16] !== e.peak) begin
          $error("block_peak_envelope: expected %0d, got %0d", e.peak, m_tdata[38:16]);
          mismatches++;
        end
        if (m_tuser !== e.duck) begin
          $error("ducking_active: expected %0d, got %0d", e.duck, m_tuser);
          mismatches++;
        end
      end
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
    end else if (m_tready) begin
      if (!steady_sink && $urandom_range(0, 9) < 3) begin
        m_tready <= 1'b0;
        hold_cnt = pick_pause() - 1;
      end
    end else begin
      m_tready <= 1'b1;
      hold_cnt = $urandom_range(0, 8);
    end
  end

  initial begin
    #4_000_000;
    $display("sidechain_peak_envelope_ducker_top_test NOT OK");
    $finish;
  end

  initial begin
    frame_t f;
    int len;
    int in_phase;
    bit broken;

    // reset settings: attack at unity, ducking off, both channels
    add_checked('0, '0, GAIN_ONE, '0, 1'b0);
    add_checked(SMP_MIN, '0, GAIN_ONE, LEVEL_TOP, 1'b0);
    add_frame(SMP_MAX, -24'sd8388607, 1'b0);
    add_checked('0, '0, GAIN_ONE, LEVEL_TOP, 1'b0);
    add_frame('0, SMP_MIN, 1'b1);
    // ducking on, zero threshold, gain and coefficients above unity, left only
    add_cfg(REG_DUCK_ENABLE, 23'h7FFFFF);
    add_cfg(REG_THRESHOLD, '0);
    add_cfg(REG_DUCK_GAIN, 23'h00FFFF);
    add_cfg(REG_ATTACK, 23'h01FFFF);
    add_cfg(REG_RELEASE, 23'h01FFFF);
    add_cfg(REG_ACTIVE_CH, 23'd1);
    add_cfg(REG_SPARE_LO, 23'h7FFFFF);
    add_cfg(REG_SPARE_HI, '0);
    add_checked(SMP_MAX, '0, GAIN_ONE, LEVEL_TOP, 1'b1);
    add_checked('0, SMP_MIN, GAIN_ONE, LEVEL_TOP, 1'b1);
    add_checked(24'd1, SMP_MIN, GAIN_ONE, 23'd1, 1'b1);
    // frozen envelope, zero gain, channel count zero
    add_cfg(REG_DUCK_GAIN, '0);
    add_cfg(REG_ACTIVE_CH, '0);
    add_cfg(REG_ATTACK, '0);
    add_cfg(REG_RELEASE, '0);
    add_checked(SMP_MIN, SMP_MAX, 16'd0, 23'd1, 1'b1);
    // channel count three, top threshold, half coefficients
    add_cfg(REG_ACTIVE_CH, 23'd3);
    add_cfg(REG_THRESHOLD, 23'h7FFFFF);
    add_cfg(REG_ATTACK, 23'd32768);
    add_cfg(REG_RELEASE, 23'd32768);
    add_cfg(REG_DUCK_GAIN, 23'd16384);
    add_frame(24'd100000, -24'sd200000, 1'b0);
    add_frame(-24'sd5, 24'd4000000, 1'b0);
    add_frame('0, '0, 1'b0);
    add_frame(24'd123, -24'sd123, 1'b1);
    add_cfg(REG_THRESHOLD, 23'd1);
    add_frame(SMP_MAX, SMP_MAX, 1'b1);
    add_cfg(REG_DUCK_ENABLE, '0);
    add_frame(SMP_MIN, SMP_MIN, 1'b1);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain();
        cfg_write(rows[i].idx, rows[i].val);
      end else begin
        send_frame(rows[i].f, rows[i].typed, rows[i].want);
      end
    end

    for (int ph = 0; ph < 12; ph++) begin
      drain();
      settings_used++;
      if (ph == 0) begin
        cfg_write(REG_ATTACK, 23'h1FFFF);
        cfg_write(REG_RELEASE, 23'h1FFFF);
        cfg_write(REG_THRESHOLD, 23'h7FFFFF);
        cfg_write(REG_DUCK_GAIN, 23'hFFFF);
        cfg_write(REG_DUCK_ENABLE, 23'd1);
        cfg_write(REG_ACTIVE_CH, 23'd3);
      end else if (ph == 1) begin
        cfg_write(REG_ATTACK, '0);
        cfg_write(REG_RELEASE, '0);
        cfg_write(REG_THRESHOLD, '0);
        cfg_write(REG_DUCK_GAIN, '0);
        cfg_write(REG_DUCK_ENABLE, 23'd1);
        cfg_write(REG_ACTIVE_CH, '0);
      end else begin
        case ($urandom_range(0, 2))
          0: cfg_write(REG_ATTACK, {6'($urandom), 17'd65536});
          1: cfg_write(REG_ATTACK, {6'($urandom), 17'($urandom)});
          default: cfg_write(REG_ATTACK, {6'($urandom), 17'($urandom_range(1, 2000))});
        endcase
        case ($urandom_range(0, 2))
          0: cfg_write(REG_RELEASE, {6'($urandom), 17'($urandom_range(1, 2000))});
          1: cfg_write(REG_RELEASE, {6'($urandom), 17'($urandom)});
          default: cfg_write(REG_RELEASE, {6'($urandom), 17'($urandom_range(0, 65536))});
        endcase
        if ($urandom_range(0, 1))
          cfg_write(REG_THRESHOLD, 23'($urandom));
        else
          cfg_write(REG_THRESHOLD, 23'($urandom_range(0, 1 << $urandom_range(4, 22))));
        cfg_write(REG_DUCK_GAIN, {7'($urandom), 16'($urandom)});
        cfg_write(REG_DUCK_ENABLE, {22'($urandom), 1'($urandom_range(0, 3) != 0)});
        cfg_write(REG_ACTIVE_CH, {21'($urandom), 2'($urandom)});
        if ($urandom_range(0, 1)) cfg_write(REG_SPARE_HI, 23'($urandom));
      end
      steady_src = ($urandom_range(0, 3) == 0);
      steady_sink = ($urandom_range(0, 3) == 0);

      in_phase = 0;
      while (in_phase < 84) begin
        case ($urandom_range(0, 19))
          0, 1, 2: len = $urandom_range(13, 40);
          default: len = $urandom_range(1, 12);
        endcase
        // now and then a run with scattered or missing block ends
        broken = ($urandom_range(0, 19) == 0);
        for (int k = 0; k < len; k++) begin
          f.left = pick_sample();
          f.right = pick_sample();
          f.last = broken ? ($urandom_range(0, 3) == 0) : (k == len - 1);
          send_frame(f, 1'b0, '0);
          in_phase++;
        end
      end
    end

    drain();
    if (awaited_blocks.size() != 0) begin
      $error("%0d block results never arrived", awaited_blocks.size());
      mismatches++;
    end
    $display("covered %0d frames over %0d register settings", frames_sent, settings_used);
    $display("%0d block results compared, %0d mismatches", blocks_checked, mismatches);
    if (mismatches == 0) $display("sidechain_peak_envelope_ducker_top_test OK");
    else $display("sidechain_peak_envelope_ducker_top_test NOT OK");
    $finish;
  end

endmodule

FILE: files.f
rtl/sped_pkg.sv
rtl/sped_lane.sv
rtl/sped_env.sv
rtl/sidechain_peak_envelope_ducker_top.sv
tb/sidechain_peak_envelope_ducker_top_test.sv
